@@ design/fdt_pkg.sv @@
// fdt_pkg: shared constants and helpers for the fixed point to decimal text unit
// holds ascii codes, rounding constants and the power of ten table
// no dependencies
package fdt_pkg;

   // field widths
   localparam int ValueWidth  = 64;
   localparam int CharWidth   = 8;
   localparam int PrecWidth   = 4;
   localparam int ScaledWidth = 62;
   localparam int WholeWidth  = 31;
   localparam int QuotWidth   = 30;

   // precision clamp and rounding midpoint
   localparam logic [PrecWidth-1:0] MaxPrec   = 4'd9;
   localparam logic [31:0]          HalfPoint = 32'h8000_0000;

   // ascii codes
   localparam logic [CharWidth-1:0] AsciiZero  = 8'd48;
   localparam logic [CharWidth-1:0] AsciiMinus = 8'd45;
   localparam logic [CharWidth-1:0] AsciiPoint = 8'd46;
   localparam logic [CharWidth-1:0] AsciiNone  = 8'd0;

   // ten to the given precision, precision clamped to nine
   function automatic logic [QuotWidth-1:0] ten_power(input logic [PrecWidth-1:0] prec);
      logic [QuotWidth-1:0] res;
      unique case (prec)
         4'd0: res = 30'd1;
         4'd1: res = 30'd10;
         4'd2: res = 30'd100;
         4'd3: res = 30'd1000;
         4'd4: res = 30'd10000;
         4'd5: res = 30'd100000;
         4'd6: res = 30'd1000000;
         4'd7: res = 30'd10000000;
         4'd8: res = 30'd100000000;
         default: res = 30'd1000000000;
      endcase
      return res;
   endfunction

   // double dabble digit correction
   function automatic logic [3:0] dabble(input logic [3:0] digit);
      return (digit >= 4'd5) ? digit + 4'd3 : digit;
   endfunction

endpackage

@@ design/fixed_to_decimal_text_unit.sv @@
// fixed_to_decimal_text_unit: signed Q31.32 value to decimal ascii text, one char per transfer
// uses fdt_pkg for constants, the power of ten table and the bcd digit correction
//
//   channel  dir  signals                          payload
//   req      in   req_tvalid/tready/tdata[63:0]    value (Q31.32, two's complement)
//   rsp      out  rsp_tvalid/tready/tdata/tlast/   character in tdata, last in tlast,
//                 tuser                            too_large in tuser
//   csr      in   csr_valid/ready/data[3:0]        fraction_digits
//
// one item runs P scaling steps (P = fraction digits), 31 shift-and-correct steps of the
// serial binary to bcd converter, up to 9 skips of leading integer zeros, and N <= 21
// characters at one per cycle while rsp is not stalled.
// a new item is taken once the last character of the previous one sits in the
// output register; rsp stalls simply hold the emit sequence.
// reset is synchronous and active high; fraction_digits resets to nine.
module fixed_to_decimal_text_unit (
   input  logic                            clock,
   input  logic                            reset,
   // value (bits 63:0)
   input  logic [fdt_pkg::ValueWidth-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // character (bits 7:0)
   output logic [fdt_pkg::CharWidth-1:0]   rsp_tdata,
   // too_large (bit 0)
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fdt_pkg::PrecWidth-1:0]   csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_NEGATE, ST_SCALE, ST_ROUND, ST_CONVERT, ST_ALIGN,
      ST_SKIP, ST_SIGN, ST_INT, ST_POINT, ST_FRAC, ST_OVF
   } state_type;

   state_type                          state_ff, state_in;
   logic [fdt_pkg::PrecWidth-1:0]      cfg_prec_ff, cfg_prec_in;
   logic [fdt_pkg::PrecWidth-1:0]      prec_ff, prec_in;
   logic [fdt_pkg::ValueWidth-1:0]     raw_ff, raw_in;
   logic                               neg_ff, neg_in;
   logic [fdt_pkg::ScaledWidth-1:0]    prod_ff, prod_in;
   logic [fdt_pkg::WholeWidth-1:0]     whole_ff, whole_in;
   logic [fdt_pkg::WholeWidth-1:0]     quot_ff, quot_in;
   logic                               qnz_ff, qnz_in;
   logic [39:0]                        ibcd_ff, ibcd_in;
   logic [35:0]                        fbcd_ff, fbcd_in;
   logic [4:0]                         cnt_ff, cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [fdt_pkg::CharWidth-1:0]      rsp_char_ff, rsp_char_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_user_ff, rsp_user_in;

   // combinational helpers
   logic                               out_free;
   logic [fdt_pkg::ValueWidth-1:0]     abs_val;
   logic                               too_large;
   logic [fdt_pkg::QuotWidth-1:0]      q_raw, q_inc, scale;
   logic [31:0]                        rem;
   logic                               above, tie, round_up;
   logic [39:0]                        ibcd_adj;
   logic [35:0]                        fbcd_adj;
   logic [5:0]                         align_amt;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // magnitude and range check
   assign abs_val   = neg_ff ? (~raw_ff + 64'd1) : raw_ff;
   assign too_large = abs_val[63] || ((&abs_val[62:32]) && (|abs_val[31:0]));

   // rounding terms of the scaled fraction
   assign q_raw = prod_ff[61:32];
   assign rem   = prod_ff[31:0];
   assign q_inc = q_raw + 30'd1;
   assign scale = fdt_pkg::ten_power(prec_ff);
   assign above = rem > fdt_pkg::HalfPoint;
   assign tie   = rem == fdt_pkg::HalfPoint;

   // bcd digit corrections, one per digit
   always_comb begin
      for (int d = 0; d < 10; d++) begin
         ibcd_adj[d*4 +: 4] = fdt_pkg::dabble(ibcd_ff[d*4 +: 4]);
      end
      for (int d = 0; d < 9; d++) begin
         fbcd_adj[d*4 +: 4] = fdt_pkg::dabble(fbcd_ff[d*4 +: 4]);
      end
   end

   // fraction digits sit left aligned before emit
   assign align_amt = {fdt_pkg::MaxPrec - prec_ff, 2'b00};
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      cfg_prec_in  = cfg_prec_ff;
      prec_in      = prec_ff;
      raw_in       = raw_ff;
      neg_in       = neg_ff;
      prod_in      = prod_ff;
      whole_in     = whole_ff;
      quot_in      = quot_ff;
      qnz_in       = qnz_ff;
      ibcd_in      = ibcd_ff;
      fbcd_in      = fbcd_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_user_in  = rsp_user_ff;
      round_up     = 1'b0;

      // configuration write
      if (csr_valid) begin
         cfg_prec_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata;
               neg_in   = req_tdata[63];
               prec_in  = (cfg_prec_ff > fdt_pkg::MaxPrec) ? fdt_pkg::MaxPrec : cfg_prec_ff;
               state_in = ST_NEGATE;
            end
         end
         ST_NEGATE: begin
            whole_in = abs_val[62:32];
            prod_in  = {30'd0, abs_val[31:0]};
            cnt_in   = {1'b0, prec_ff};
            state_in = too_large ? ST_OVF : ST_SCALE;
         end
         // multiply the fraction by ten once per step
         ST_SCALE: begin
            if (cnt_ff == 5'd0) begin
               state_in = ST_ROUND;
            end else begin
               prod_in = (prod_ff << 3) + (prod_ff << 1);
               cnt_in  = cnt_ff - 5'd1;
            end
         end
         ST_ROUND: begin
            if (prec_ff == 4'd0) begin
               round_up = above || (tie && whole_ff[0]);
               whole_in = whole_ff + {30'd0, round_up};
               quot_in  = '0;
               qnz_in   = 1'b0;
            end else begin
               round_up = above || (tie && ((q_raw == 30'd0) || q_raw[0]));
               if (round_up && (q_inc == scale)) begin
                  quot_in  = '0;
                  qnz_in   = 1'b0;
                  whole_in = whole_ff + 31'd1;
               end else if (round_up) begin
                  quot_in = {1'b0, q_inc};
                  qnz_in  = 1'b1;
               end else begin
                  quot_in = {1'b0, q_raw};
                  qnz_in  = (q_raw != 30'd0);
               end
            end
            ibcd_in  = '0;
            fbcd_in  = '0;
            cnt_in   = 5'd31;
            state_in = ST_CONVERT;
         end
         // serial binary to bcd, both parts side by side
         ST_CONVERT: begin
            ibcd_in  = {ibcd_adj[38:0], whole_ff[30]};
            fbcd_in  = {fbcd_adj[34:0], quot_ff[30]};
            whole_in = {whole_ff[29:0], 1'b0};
            quot_in  = {quot_ff[29:0], 1'b0};
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            fbcd_in  = fbcd_ff << align_amt;
            cnt_in   = 5'd10;
            state_in = ST_SKIP;
         end
         // drop leading zeros of the integer, keep at least one digit
         ST_SKIP: begin
            if ((ibcd_ff[39:36] == 4'd0) && (cnt_ff != 5'd1)) begin
               ibcd_in = {ibcd_ff[35:0], 4'd0};
               cnt_in  = cnt_ff - 5'd1;
            end else begin
               state_in = neg_ff ? ST_SIGN : ST_INT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fdt_pkg::AsciiMinus;
               rsp_last_in  = 1'b0;
               rsp_user_in  = 1'b0;
               state_in     = ST_INT;
            end
         end
         ST_INT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fdt_pkg::AsciiZero + {4'd0, ibcd_ff[39:36]};
               rsp_last_in  = (cnt_ff == 5'd1) && !qnz_ff;
               rsp_user_in  = 1'b0;
               ibcd_in      = {ibcd_ff[35:0], 4'd0};
               cnt_in       = cnt_ff - 5'd1;
               if (cnt_ff == 5'd1) begin
                  state_in = qnz_ff ? ST_POINT : ST_IDLE;
               end
            end
         end
         ST_POINT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fdt_pkg::AsciiPoint;
               rsp_last_in  = 1'b0;
               rsp_user_in  = 1'b0;
               state_in     = ST_FRAC;
            end
         end
         // trailing zeros end the text early
         ST_FRAC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fdt_pkg::AsciiZero + {4'd0, fbcd_ff[35:32]};
               rsp_last_in  = (fbcd_ff[31:0] == 32'd0);
               rsp_user_in  = 1'b0;
               fbcd_in      = {fbcd_ff[31:0], 4'd0};
               if (fbcd_ff[31:0] == 32'd0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_OVF: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = fdt_pkg::AsciiNone;
               rsp_last_in  = 1'b1;
               rsp_user_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_prec_ff  <= fdt_pkg::MaxPrec;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_prec_ff  <= cfg_prec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      prec_ff     <= prec_in;
      raw_ff      <= raw_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      whole_ff    <= whole_in;
      quot_ff     <= quot_in;
      qnz_ff      <= qnz_in;
      ibcd_ff     <= ibcd_in;
      fbcd_ff     <= fbcd_in;
      cnt_ff      <= cnt_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_user_ff <= rsp_user_in;
   end

   // rounded fraction stays below ten to the precision
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT) && (cnt_ff == 5'd31)
         |-> (quot_ff < {1'b0, fdt_pkg::ten_power(prec_ff)}))
      else $error("rounded fraction out of range");

   // converter leaves only decimal digits
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INT) |-> (ibcd_ff[39:36] <= 4'd9) && (cnt_ff != 5'd0))
      else $error("bad integer digit or count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRAC) |-> (fbcd_ff[35:32] <= 4'd9))
      else $error("bad fraction digit");

   // a new item only follows a finished text
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && $past(state_ff != ST_IDLE))
         |-> $past(rsp_valid_in && rsp_last_in))
      else $error("item accepted before text finished");

endmodule
